/* hdl/segment_sphere_intersect_defines.svh */
// Assertion macros used by the RTL file of the segment versus sphere block.
`ifndef SEGMENT_SPHERE_INTERSECT_DEFINES_SVH
`define SEGMENT_SPHERE_INTERSECT_DEFINES_SVH

`ifndef SYNTHESIS
`define SSI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SSI_ASSERT(lbl, clk, rstn, prop, msg)
`define SSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hdl/ssi_pkg.sv */
package ssi_pkg;

  typedef struct packed {
    logic pp_en;
    logic sum_en;
  } mul_ctl_t;

endpackage

/* hdl/ssi_if.sv */
interface ssi_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [COORD_WIDTH-2:0] radius;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z,
    output center_x, center_y, center_z, radius,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
    input  center_x, center_y, center_z, radius,
    output ready
  );
endinterface

interface ssi_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

/* hdl/ssi_wide_mul.sv */
module ssi_wide_mul #(
  parameter int WIDTH = 34
) (
  input  logic                 clk_i,
  input  ssi_pkg::mul_ctl_t    ctl_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic [2*WIDTH-1:0]   p_o
);

  localparam int LoW = (WIDTH + 1) / 2;
  localparam int HiW = WIDTH - LoW;
  localparam int LlW = 2 * LoW;
  localparam int HhW = 2 * HiW;
  localparam int PW  = 2 * WIDTH;

  logic [LoW-1:0]   a_lo, b_lo;
  logic [HiW-1:0]   a_hi, b_hi;
  logic [LlW-1:0]   ll_d, ll_q;
  logic [WIDTH-1:0] lh_d, lh_q, hl_d, hl_q;
  logic [HhW-1:0]   hh_d, hh_q;
  logic [PW-1:0]    p_d, p_q;

  assign a_lo = a_i[LoW-1:0];
  assign b_lo = b_i[LoW-1:0];
  assign a_hi = a_i[WIDTH-1:LoW];
  assign b_hi = b_i[WIDTH-1:LoW];

  always_comb begin
    ll_d = LlW'(a_lo) * LlW'(b_lo);
    lh_d = WIDTH'(a_lo) * WIDTH'(b_hi);
    hl_d = WIDTH'(a_hi) * WIDTH'(b_lo);
    hh_d = HhW'(a_hi) * HhW'(b_hi);
  end

  always_comb begin
    p_d = (PW'(hh_q) << LlW) + ((PW'(lh_q) + PW'(hl_q)) << LoW) + PW'(ll_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.pp_en) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
    if (ctl_i.sum_en) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

/* hdl/segment_sphere_intersect.sv */
// Channel    Dir  Handshake      Payload
// item_i     in   valid / ready  start_x..z, end_x..z, center_x..z, radius
// result_o   out  valid / ready  hit
//
// Seven register stages: differences, products, sums, compares, partial
// products, product sums, final compare. One item enters per cycle unless
// every stage is full and the output stalls. The stage valid bits are
// cleared by rst_ni; data registers are not reset. A stage holds only while
// it is full and the stage after it holds, so bubbles fill and a stalled
// output still lets items enter until every stage is full.
`include "segment_sphere_intersect_defines.svh"

module segment_sphere_intersect #(
  parameter int COORD_WIDTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ssi_in_if.sink    item_i,
  ssi_out_if.source result_o
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int PW     = 2 * DW;
  localparam int SqW    = 2 * COORD_WIDTH + 2;
  localparam int SqEW   = SqW - 1;
  localparam int DotW   = SqW + 1;
  localparam int RrW    = 2 * COORD_WIDTH - 2;
  localparam int Stages = 7;

  logic [Stages-1:0] v_d, v_q, en;

  // Stage 1: differences.
  logic signed [DW-1:0] s_ext[3], e_ext[3], c_ext[3];
  logic signed [DW-1:0] ab_d[3], ac_d[3], ec_d[3];
  logic signed [DW-1:0] ab_q[3], ac_q[3], ec_q[3];
  logic [COORD_WIDTH-2:0] r_q;

  // Stage 2: products.
  logic signed [PW-1:0] pab[3], pac[3], pec[3], pdot[3];
  logic [SqEW-1:0] sq_ab_d[3], sq_ac_d[3], sq_ec_d[3];
  logic [SqEW-1:0] sq_ab_q[3], sq_ac_q[3], sq_ec_q[3];
  logic signed [PW-1:0] pd_q[3];
  logic [RrW-1:0] rr_d, rr_q;

  // Stage 3: sums.
  logic [SqW-1:0] len3_d, len3_q, a3_d, a3_q, e3_d, e3_q, rr3_d, rr3_q;
  logic signed [DotW-1:0] dot3_d, dot3_q;

  // Stage 4: compares.
  logic len_zero, dot_pos, dot_ge, a_le_r, e_le_r;
  logic need4_d, need4_q, fast4_d, fast4_q;
  logic [SqW-1:0] diff4_d, diff4_q, dotm4_d, dotm4_q, len4_q;

  // Stages 5 and 6: wide products.
  ssi_pkg::mul_ctl_t mul_ctl;
  logic [2*SqW-1:0] lhs, rhs;
  logic need5_q, fast5_q, need6_q, fast6_q;

  // Stage 7: result.
  logic hit_d, hit_q;

  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || result_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = item_i.valid;
    end
    for (int k = 1; k < Stages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_comb begin
    s_ext[0] = DW'(item_i.start_x);
    s_ext[1] = DW'(item_i.start_y);
    s_ext[2] = DW'(item_i.start_z);
    e_ext[0] = DW'(item_i.end_x);
    e_ext[1] = DW'(item_i.end_y);
    e_ext[2] = DW'(item_i.end_z);
    c_ext[0] = DW'(item_i.center_x);
    c_ext[1] = DW'(item_i.center_y);
    c_ext[2] = DW'(item_i.center_z);
    for (int i = 0; i < 3; i++) begin
      ab_d[i] = e_ext[i] - s_ext[i];
      ac_d[i] = c_ext[i] - s_ext[i];
      ec_d[i] = c_ext[i] - e_ext[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pab[i]     = ab_q[i] * ab_q[i];
      pac[i]     = ac_q[i] * ac_q[i];
      pec[i]     = ec_q[i] * ec_q[i];
      pdot[i]    = ac_q[i] * ab_q[i];
      sq_ab_d[i] = pab[i][SqEW-1:0];
      sq_ac_d[i] = pac[i][SqEW-1:0];
      sq_ec_d[i] = pec[i][SqEW-1:0];
    end
    rr_d = RrW'(r_q) * RrW'(r_q);
  end

  always_comb begin
    len3_d = SqW'(sq_ab_q[0]) + SqW'(sq_ab_q[1]) + SqW'(sq_ab_q[2]);
    a3_d   = SqW'(sq_ac_q[0]) + SqW'(sq_ac_q[1]) + SqW'(sq_ac_q[2]);
    e3_d   = SqW'(sq_ec_q[0]) + SqW'(sq_ec_q[1]) + SqW'(sq_ec_q[2]);
    dot3_d = DotW'(pd_q[0]) + DotW'(pd_q[1]) + DotW'(pd_q[2]);
    rr3_d  = SqW'(rr_q);
  end

  always_comb begin
    len_zero = (len3_q == '0);
    dot_pos  = !dot3_q[DotW-1] && (dot3_q != '0);
    dot_ge   = (dot3_q >= $signed({1'b0, len3_q}));
    a_le_r   = (a3_q <= rr3_q);
    e_le_r   = (e3_q <= rr3_q);
    if (len_zero || !dot_pos) begin
      fast4_d = a_le_r;
      need4_d = 1'b0;
    end else if (dot_ge) begin
      fast4_d = e_le_r;
      need4_d = 1'b0;
    end else begin
      fast4_d = a_le_r;
      need4_d = !a_le_r;
    end
    diff4_d = a3_q - rr3_q;
    dotm4_d = dot3_q[SqW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ab_q <= ab_d;
      ac_q <= ac_d;
      ec_q <= ec_d;
      r_q  <= item_i.radius;
    end
    if (en[1]) begin
      sq_ab_q <= sq_ab_d;
      sq_ac_q <= sq_ac_d;
      sq_ec_q <= sq_ec_d;
      pd_q    <= pdot;
      rr_q    <= rr_d;
    end
    if (en[2]) begin
      len3_q <= len3_d;
      a3_q   <= a3_d;
      e3_q   <= e3_d;
      dot3_q <= dot3_d;
      rr3_q  <= rr3_d;
    end
    if (en[3]) begin
      need4_q <= need4_d;
      fast4_q <= fast4_d;
      diff4_q <= diff4_d;
      dotm4_q <= dotm4_d;
      len4_q  <= len3_q;
    end
    if (en[4]) begin
      need5_q <= need4_q;
      fast5_q <= fast4_q;
    end
    if (en[5]) begin
      need6_q <= need5_q;
      fast6_q <= fast5_q;
    end
    if (en[6]) begin
      hit_q <= hit_d;
    end
  end

  assign mul_ctl.pp_en  = en[4];
  assign mul_ctl.sum_en = en[5];

  ssi_wide_mul #(
    .WIDTH (SqW)
  ) u_mul_lhs (
    .clk_i (clk_i),
    .ctl_i (mul_ctl),
    .a_i   (diff4_q),
    .b_i   (len4_q),
    .p_o   (lhs)
  );

  ssi_wide_mul #(
    .WIDTH (SqW)
  ) u_mul_rhs (
    .clk_i (clk_i),
    .ctl_i (mul_ctl),
    .a_i   (dotm4_q),
    .b_i   (dotm4_q),
    .p_o   (rhs)
  );

  assign hit_d = need6_q ? (lhs <= rhs) : fast6_q;

  assign item_i.ready   = en[0];
  assign result_o.valid = v_q[Stages-1];
  assign result_o.hit   = hit_q;

  `SSI_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, item_i.valid && item_i.ready, v_q[0], "accepted item missing from first stage")
  `SSI_ASSERT(a_interior_range, clk_i, rst_ni, (v_q[3] && need4_q) |-> (dotm4_q < len4_q && diff4_q != '0), "interior case with projection out of range")
  `SSI_ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, v_q[0] && !en[1], v_q[0] && $stable(ab_q[0]), "held first stage lost its item")
  `SSI_ASSERT(a_ready_full, clk_i, rst_ni, !item_i.ready |-> (&v_q), "input stalled while a stage is empty")

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_W      = 16;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 1100;
  localparam int LATENCY      = 7;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx, sy, sz;
    logic signed [COORD_W-1:0] ex, ey, ez;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic        [COORD_W-2:0] radius;
  } segment_t;

  localparam int SEG_W = $bits(segment_t);

  typedef struct packed {
    segment_t seg;
    logic     known;
    logic     hit;
  } directed_row_t;

  typedef struct {
    int   index;
    logic hit;
  } pending_hit_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ssi_in_if #(.COORD_WIDTH(COORD_W)) item_if ();
  ssi_out_if result_if ();

  segment_sphere_intersect #(.COORD_WIDTH(COORD_W)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  pending_hit_t pending_hits[$];
  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int hits_seen    = 0;
  int stall_cycles = 0;
  int src_idle_pct = 27;
  int snk_idle_pct = 71;

  // Where the hit is known it is typed in; zero marks a row left to the predictor.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1},
    '{'{100, 0, 0, 100, 0, 0, 0, 0, 0, 99}, 1, 0},
    '{'{100, 0, 0, 100, 0, 0, 0, 0, 0, 100}, 1, 1},
    '{'{-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0}, 1, 1},
    '{'{0, 0, 0, 100, 0, 0, -50, 0, 0, 49}, 1, 0},
    '{'{0, 0, 0, 100, 0, 0, -50, 0, 0, 50}, 1, 1},
    '{'{0, 0, 0, 100, 0, 0, 150, 0, 0, 50}, 1, 1},
    '{'{0, 0, 0, 100, 0, 0, 150, 0, 0, 49}, 1, 0},
    '{'{0, 0, 0, 100, 0, 0, 50, 30, 0, 30}, 1, 1},
    '{'{0, 0, 0, 100, 0, 0, 50, 30, 0, 29}, 1, 0},
    '{'{0, 0, 0, 100, 0, 0, 100, 40, 0, 40}, 1, 1},
    '{'{0, 0, 0, 100, 0, 0, 0, 40, 0, 39}, 1, 0},
    '{'{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768, 32767}, 1, 0},
    '{'{0, 0, 0, 100, 0, 0, 10, 5, 0, 20}, 1, 1},
    '{'{-100, -100, -100, -200, -100, -100, -150, -120, -100, 20}, 1, 1},
    '{'{-100, -100, -100, -200, -100, -100, -150, -120, -100, 19}, 1, 0},
    '{'{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767}, 0, 0},
    '{'{-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 0, 32767}, 0, 0},
    '{'{1234, -567, 89, -4321, 765, -98, 100, 200, 300, 5000}, 0, 0},
    '{'{-32768, 0, 32767, -32768, 0, 32767, -32767, 1, 32766, 1}, 0, 0}
  };

  always #5 clk_i = ~clk_i;

  function automatic logic sphere_hit(segment_t seg);
    logic signed [95:0] sv[3], ev[3], cv[3];
    logic signed [95:0] len2, ac2, ec2, dot, rr;
    sv[0] = $signed(seg.sx);
    sv[1] = $signed(seg.sy);
    sv[2] = $signed(seg.sz);
    ev[0] = $signed(seg.ex);
    ev[1] = $signed(seg.ey);
    ev[2] = $signed(seg.ez);
    cv[0] = $signed(seg.cx);
    cv[1] = $signed(seg.cy);
    cv[2] = $signed(seg.cz);
    rr    = {81'd0, seg.radius};
    rr    = rr * rr;
    len2  = 0;
    ac2   = 0;
    ec2   = 0;
    dot   = 0;
    for (int i = 0; i < 3; i++) begin
      len2 += (ev[i] - sv[i]) * (ev[i] - sv[i]);
      ac2  += (cv[i] - sv[i]) * (cv[i] - sv[i]);
      ec2  += (cv[i] - ev[i]) * (cv[i] - ev[i]);
      dot  += (cv[i] - sv[i]) * (ev[i] - sv[i]);
    end
    if (len2 == 0 || dot <= 0) return ac2 <= rr;
    if (dot >= len2) return ec2 <= rr;
    return (ac2 <= rr) || ((ac2 - rr) * len2 <= dot * dot);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] corner_value();
    case ($urandom_range(6))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sh7ffe;
      default: return 16'sh7fff;
    endcase
  endfunction

  // Most segments put the center at a random offset from a point on or just beyond
  // the segment, with the radius close to that offset, so hits and misses both occur.
  function automatic segment_t random_segment();
    segment_t seg;
    int mode, span, t, rad, mag2;
    int base[3], dir[3], off[3];
    mode = $urandom_range(99);
    seg  = SEG_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode < 15) return seg;
    if (mode < 27) begin
      seg.sx = corner_value();
      seg.sy = corner_value();
      seg.sz = corner_value();
      seg.ex = corner_value();
      seg.ey = corner_value();
      seg.ez = corner_value();
      seg.cx = corner_value();
      seg.cy = corner_value();
      seg.cz = corner_value();
      case ($urandom_range(3))
        0: seg.radius = '0;
        1: seg.radius = '1;
        default: ;
      endcase
      return seg;
    end
    span = ($urandom_range(9) == 0) ? 30000 : ($urandom_range(1) ? 2000 : 200);
    mag2 = 0;
    for (int i = 0; i < 3; i++) begin
      base[i] = int'($urandom_range(65535)) - 32768;
      dir[i]  = (mode < 35) ? 0 : int'($urandom_range(2 * span)) - span;
      off[i]  = int'($urandom_range(span / 2)) - span / 4;
      mag2   += off[i] * off[i];
    end
    t   = int'($urandom_range(24)) - 4;
    rad = int'($sqrt(real'(mag2))) + int'($urandom_range(6)) - 3;
    if (rad < 0) rad = 0;
    if (rad > 32767) rad = 32767;
    seg.sx     = sat16(base[0]);
    seg.sy     = sat16(base[1]);
    seg.sz     = sat16(base[2]);
    seg.ex     = sat16(base[0] + dir[0]);
    seg.ey     = sat16(base[1] + dir[1]);
    seg.ez     = sat16(base[2] + dir[2]);
    seg.cx     = sat16(base[0] + dir[0] * t / 16 + off[0]);
    seg.cy     = sat16(base[1] + dir[1] * t / 16 + off[1]);
    seg.cz     = sat16(base[2] + dir[2] * t / 16 + off[2]);
    seg.radius = rad[COORD_W-2:0];
    return seg;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_segment(segment_t seg, logic known, logic known_hit);
    pending_hit_t entry;
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid    <= 1'b1;
    item_if.start_x  <= seg.sx;
    item_if.start_y  <= seg.sy;
    item_if.start_z  <= seg.sz;
    item_if.end_x    <= seg.ex;
    item_if.end_y    <= seg.ey;
    item_if.end_z    <= seg.ez;
    item_if.center_x <= seg.cx;
    item_if.center_y <= seg.cy;
    item_if.center_z <= seg.cz;
    item_if.radius   <= seg.radius;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    entry.index = items_sent;
    entry.hit   = known ? known_hit : sphere_hit(seg);
    pending_hits.push_back(entry);
    items_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    pending_hit_t oldest;
    if (rst_ni) begin
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (pending_hits.size() == 0) begin
          report_mismatch("result arrived with no segment pending");
        end else begin
          oldest = pending_hits.pop_front();
          if (oldest.hit) hits_seen++;
          if (result_if.hit !== oldest.hit) begin
            report_mismatch($sformatf("segment %0d: hit %b, expected %b",
                                      oldest.index, result_if.hit, oldest.hit));
          end
        end
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: timeout after %0d cycles without a handshake", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int total;
    item_if.valid    = 1'b0;
    item_if.start_x  = '0;
    item_if.start_y  = '0;
    item_if.start_z  = '0;
    item_if.end_x    = '0;
    item_if.end_y    = '0;
    item_if.end_z    = '0;
    item_if.center_x = '0;
    item_if.center_y = '0;
    item_if.center_z = '0;
    item_if.radius   = '0;
    total            = NUM_DIRECTED + NUM_RANDOM;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        src_idle_pct = 71;
        snk_idle_pct = 27;
      end else if (i == 2 * total / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (i < NUM_DIRECTED) begin
        send_segment(directed_rows[i].seg, directed_rows[i].known, directed_rows[i].hit);
      end else begin
        send_segment(random_segment(), 1'b0, 1'b0);
      end
    end
    item_if.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("summary: %0d segments sent (%0d directed), %0d results checked, %0d hits",
             items_sent, NUM_DIRECTED, results_seen, hits_seen);
    $display("summary: idling sender/receiver 27/71, then 71/27, then none; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* segment_sphere_intersect.f */
+incdir+hdl
hdl/ssi_pkg.sv
hdl/ssi_if.sv
hdl/ssi_wide_mul.sv
hdl/segment_sphere_intersect.sv
test/testbench.sv
